// ===== rtl/four_lane_word_hash_defines.svh =====
// Assertion macros shared by the four-lane word hash RTL.
// Depends on nothing; modules that use them provide clk and arst_n.
`ifndef FOUR_LANE_WORD_HASH_DEFINES_SVH
`define FOUR_LANE_WORD_HASH_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define FLWH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: assertion failed");
// expression must never be true out of reset
`define FLWH_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define FLWH_ASSERT(lbl, prop)
`define FLWH_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/flwh_pkg.sv =====
// Shared types, constants and helper functions of the four-lane word hash.
// No dependencies; used by flwh_mulmod and four_lane_word_hash.
package flwh_pkg;

	localparam int unsigned WORD_W   = 64;
	localparam int unsigned HALF_W   = WORD_W / 2;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned STEP_W   = 3;

	localparam logic [WORD_W-1:0] HASH_PRIME = 64'h6eed0e9da4d94a4f;
	localparam logic [CNT_W-1:0]  MAX_BYTES  = 4'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_C = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_D = 2'd3;

	// sequencer states of the top level
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS_M1,
		ST_ABS_M2,
		ST_FIN_GO,
		ST_FIN_M1,
		ST_FIN_M2,
		ST_EMIT
	} state_t;

	// status of the shared modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

	// middle step of the diffusion: g ^ ((g >> 32) >> (g >> 60))
	function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] g);
		logic [HALF_W-1:0] hi;
		hi = g[WORD_W-1:HALF_W] >> g[WORD_W-1:WORD_W-4];
		return g ^ {{HALF_W{1'b0}}, hi};
	endfunction

	// add modulo 2^64-1 with end-around carry; all ones stands for zero
	function automatic logic [WORD_W-1:0] eac_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage

// ===== rtl/flwh_mulmod.sv =====
// Iterative multiplier: operand * HASH_PRIME mod 2^64-1 over one 32x32 multiplier.
// Depends on flwh_pkg and four_lane_word_hash_defines.svh.
`include "four_lane_word_hash_defines.svh"

module flwh_mulmod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [flwh_pkg::WORD_W-1:0]  operand,
	output flwh_pkg::mm_stat_t           stat,
	output logic [flwh_pkg::WORD_W-1:0]  result
);

	logic [flwh_pkg::WORD_W-1:0] op_q;
	logic [flwh_pkg::WORD_W-1:0] acc_q;
	logic [flwh_pkg::WORD_W-1:0] prod_q;
	logic                        rot_q;
	logic                        pv_q;
	logic                        running_q;
	logic                        done_q;
	logic [flwh_pkg::STEP_W-1:0] step_q;

	logic [flwh_pkg::HALF_W-1:0] a_half;
	logic [flwh_pkg::HALF_W-1:0] b_half;
	logic [flwh_pkg::WORD_W-1:0] term;
	logic                        last_step;

	// operand halves for the four partial products: ll, lh, hl, hh
	always_comb begin
		a_half    = step_q[1] ? op_q[flwh_pkg::WORD_W-1:flwh_pkg::HALF_W]
				: op_q[flwh_pkg::HALF_W-1:0];
		b_half    = step_q[0] ? flwh_pkg::HASH_PRIME[flwh_pkg::WORD_W-1:flwh_pkg::HALF_W]
				: flwh_pkg::HASH_PRIME[flwh_pkg::HALF_W-1:0];
		last_step = (step_q == flwh_pkg::STEP_W'(4));
		// a 2^32 weight is a rotate by 32 modulo 2^64-1; 2^64 weight is one
		term      = rot_q ? {prod_q[flwh_pkg::HALF_W-1:0],
				prod_q[flwh_pkg::WORD_W-1:flwh_pkg::HALF_W]} : prod_q;
	end

	// multiplier stage: one partial product per cycle
	always_ff @(posedge clk) begin
		if (running_q && !last_step) begin
			prod_q <= {{flwh_pkg::HALF_W{1'b0}}, a_half} * {{flwh_pkg::HALF_W{1'b0}}, b_half};
			rot_q  <= step_q[0] ^ step_q[1];
		end
		if (start) begin
			op_q <= operand;
		end
	end

	// accumulator modulo 2^64-1
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (pv_q) begin
			acc_q <= flwh_pkg::eac_add(acc_q, term);
		end
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			pv_q      <= 1'b0;
			step_q    <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			done_q    <= 1'b0;
			pv_q      <= 1'b0;
			step_q    <= '0;
		end else if (running_q) begin
			step_q    <= step_q + flwh_pkg::STEP_W'(1);
			pv_q      <= !last_step;
			running_q <= !last_step;
			done_q    <= last_step;
		end else begin
			done_q    <= 1'b0;
		end
	end

	// all ones is the second code for zero
	assign result    = (&acc_q) ? '0 : acc_q;
	assign stat.busy = running_q;
	assign stat.done = done_q;

	`FLWH_ASSERT(a_pv_in_run, pv_q |-> running_q)
	`FLWH_ASSERT(a_done_idle, done_q |-> !running_q)
	`FLWH_ASSERT(a_done_after_last, $rose(done_q) |-> $past(last_step))

endmodule

// ===== rtl/four_lane_word_hash.sv =====
// Four-lane word hash, top level: lanes, length, sequencer and output register.
// Depends on flwh_pkg, flwh_mulmod and four_lane_word_hash_defines.svh.
//
// Usage: message words enter on the in channel (in_valid/in_ready) with
// data_word, byte_count and last_word; bytes above byte_count are ignored and
// counts above eight count as eight. A transaction with last_word set yields
// one hash_value on the out channel (out_valid/out_ready); others yield none.
// Each diffusion is two products modulo 2^64-1 through one shared 32x32
// multiplier, each product being four partial products and a final
// accumulate. A word with data is absorbed by one diffusion before in_ready
// returns; a last word adds the final diffusion before out_valid rises, and a
// last word with a byte count of zero goes to the final diffusion directly.
// The block takes one word at a time; in_ready is high only while idle.
// A result waiting in the output register does not block the next word; a
// further result waits inside the block while the receiver stalls.
// Reset clears the lanes and the length. cfg_we with cfg_index 0 to 3 writes a
// seed and loads its lane at once; write only while idle. State carries over
// from one message to the next.
`include "four_lane_word_hash_defines.svh"

module four_lane_word_hash (
	input  logic                            clk,
	input  logic                            arst_n,
	// input words
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [flwh_pkg::WORD_W-1:0]     data_word,
	input  logic [flwh_pkg::CNT_W-1:0]      byte_count,
	input  logic                            last_word,
	// hash results
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [flwh_pkg::WORD_W-1:0]     hash_value,
	// seed writes
	input  logic                            cfg_we,
	input  logic [flwh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [flwh_pkg::WORD_W-1:0]     cfg_data
);

	flwh_pkg::state_t state_q, state_d;

	logic [flwh_pkg::WORD_W-1:0] lane_a_q, lane_b_q, lane_c_q, lane_d_q;
	logic [flwh_pkg::WORD_W-1:0] len_q;
	logic [flwh_pkg::CNT_W-1:0]  cnt_q;
	logic                        last_q;
	logic                        out_valid_q;
	logic [flwh_pkg::WORD_W-1:0] hash_q;

	logic [flwh_pkg::CNT_W-1:0]  cnt_sat;
	logic [flwh_pkg::WORD_W-1:0] word_masked;
	logic                        accept;
	logic                        out_free;
	logic                        mm_start;
	logic [flwh_pkg::WORD_W-1:0] mm_operand;
	logic [flwh_pkg::WORD_W-1:0] mm_result;
	flwh_pkg::mm_stat_t          mm_stat;
	logic                        absorb_done;
	logic                        load_out;

	// byte count saturation and masking of unused bytes
	always_comb begin
		cnt_sat = (byte_count > flwh_pkg::MAX_BYTES) ? flwh_pkg::MAX_BYTES : byte_count;
		for (int i = 0; i < flwh_pkg::WORD_W / 8; i++) begin
			word_masked[i*8 +: 8] = (flwh_pkg::CNT_W'(i) < cnt_sat) ? data_word[i*8 +: 8]
					: 8'h00;
		end
	end

	assign in_ready = (state_q == flwh_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	flwh_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.operand (mm_operand),
		.stat    (mm_stat),
		.result  (mm_result)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			flwh_pkg::ST_IDLE: begin
				if (accept) begin
					if (cnt_sat != '0) begin
						state_d = flwh_pkg::ST_ABS_M1;
					end else if (last_word) begin
						state_d = flwh_pkg::ST_FIN_GO;
					end
				end
			end
			flwh_pkg::ST_ABS_M1: begin
				if (mm_stat.done) state_d = flwh_pkg::ST_ABS_M2;
			end
			flwh_pkg::ST_ABS_M2: begin
				if (mm_stat.done) state_d = last_q ? flwh_pkg::ST_FIN_GO : flwh_pkg::ST_IDLE;
			end
			flwh_pkg::ST_FIN_GO: begin
				state_d = flwh_pkg::ST_FIN_M1;
			end
			flwh_pkg::ST_FIN_M1: begin
				if (mm_stat.done) state_d = flwh_pkg::ST_FIN_M2;
			end
			flwh_pkg::ST_FIN_M2: begin
				if (mm_stat.done) state_d = out_free ? flwh_pkg::ST_IDLE : flwh_pkg::ST_EMIT;
			end
			flwh_pkg::ST_EMIT: begin
				if (out_free) state_d = flwh_pkg::ST_IDLE;
			end
			default: state_d = flwh_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier requests and update strobes
	always_comb begin
		mm_start    = 1'b0;
		mm_operand  = flwh_pkg::mix(mm_result);
		absorb_done = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			flwh_pkg::ST_IDLE: begin
				mm_start   = accept && (cnt_sat != '0);
				mm_operand = lane_a_q ^ word_masked;
			end
			flwh_pkg::ST_ABS_M1, flwh_pkg::ST_FIN_M1: begin
				mm_start = mm_stat.done;
			end
			flwh_pkg::ST_ABS_M2: begin
				absorb_done = mm_stat.done;
			end
			flwh_pkg::ST_FIN_GO: begin
				mm_start   = 1'b1;
				mm_operand = lane_a_q ^ lane_b_q ^ lane_c_q ^ lane_d_q ^ len_q;
			end
			flwh_pkg::ST_FIN_M2: begin
				load_out = mm_stat.done && out_free;
			end
			flwh_pkg::ST_EMIT: begin
				load_out = out_free;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= flwh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction fields held while the word is processed, and the output hash register
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q  <= cnt_sat;
			last_q <= last_word;
		end
		if (load_out) begin
			hash_q <= mm_result;
		end
	end

	// lanes and length; seed writes load the lanes directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_a_q <= '0;
			lane_b_q <= '0;
			lane_c_q <= '0;
			lane_d_q <= '0;
			len_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				flwh_pkg::CFG_SEED_A: lane_a_q <= cfg_data;
				flwh_pkg::CFG_SEED_B: lane_b_q <= cfg_data;
				flwh_pkg::CFG_SEED_C: lane_c_q <= cfg_data;
				flwh_pkg::CFG_SEED_D: lane_d_q <= cfg_data;
				default: lane_a_q <= lane_a_q;
			endcase
		end else if (absorb_done) begin
			lane_a_q <= lane_b_q;
			lane_b_q <= lane_c_q;
			lane_c_q <= lane_d_q;
			lane_d_q <= mm_result;
			len_q    <= len_q + {{(flwh_pkg::WORD_W-flwh_pkg::CNT_W){1'b0}}, cnt_q};
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	`FLWH_NEVER(a_start_busy, mm_start && mm_stat.busy)
	`FLWH_ASSERT(a_idle_quiet, (state_q == flwh_pkg::ST_IDLE) |-> !mm_stat.busy)
	`FLWH_ASSERT(a_done_state, mm_stat.done |-> (state_q == flwh_pkg::ST_ABS_M1 ||
		state_q == flwh_pkg::ST_ABS_M2 || state_q == flwh_pkg::ST_FIN_M1 ||
		state_q == flwh_pkg::ST_FIN_M2))
	`FLWH_NEVER(a_load_full, load_out && out_valid_q && !out_ready)

endmodule
